FILE: src/fird4_pkg.sv
// Shared types, sizes and constants of the decimating FIR filter.
// Used by fird4_mac and by the top level fir_decimate_by_four_core; depends on nothing.
`default_nettype none

package fird4_pkg;

    localparam int TAPS       = 11;
    localparam int NCOEF      = (TAPS + 1) / 2;
    localparam int DECIMATION = 4;
    localparam int PHASE_W    = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

    localparam int SAMPLE_W   = 12;
    localparam int COEF_W     = 16;
    localparam int OUT_W      = 14;
    localparam int OUT_MAX    = 8191;
    localparam int OUT_MIN    = -8192;
    localparam int SHIFT      = 15;

    // Older samples kept in the window memory, in whole groups of DECIMATION.
    localparam int HIST_ROWS  = ((TAPS - 1) / DECIMATION > 0) ? (TAPS - 1) / DECIMATION : 1;
    localparam int HIST_LEN   = HIST_ROWS * DECIMATION;
    localparam int WIN_W      = HIST_LEN * SAMPLE_W;
    localparam int LINE_LEN   = HIST_LEN + DECIMATION;
    localparam int WIN_DEPTH  = 2;
    localparam int WIN_AW     = $clog2(WIN_DEPTH);

    localparam int SYM_W      = SAMPLE_W + 1;
    localparam int PROD_W     = SYM_W + 1 + COEF_W;
    localparam int NPAIR      = (NCOEF + 1) / 2;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PAIR_W + $clog2(NPAIR) + 1;
    localparam int Q_W        = SUM_W - SHIFT;

    localparam int CFG_IDX_W  = 3;

    typedef logic [SAMPLE_W-1:0]      sample_t;
    typedef logic [SYM_W-1:0]         sym_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_0 = 3'd0,
        REG_COEF_1 = 3'd1,
        REG_COEF_2 = 3'd2,
        REG_COEF_3 = 3'd3,
        REG_COEF_4 = 3'd4,
        REG_COEF_5 = 3'd5
    } cfg_reg_t;

    localparam coef_t COEF_RESET [NCOEF] = '{
        -16'sd538, 16'sd881, 16'sd352, -16'sd3956, 16'sd8331, 16'sd22436
    };

endpackage

`default_nettype wire

FILE: src/fir_decimate_by_four_core.sv
// Top level of the 11-tap symmetric FIR decimator, decimation by four.
// Depends on fird4_pkg, fird4_ram (window memory) and fird4_mac (arithmetic pipeline).
`default_nettype none

// The block takes one 12-bit unsigned converter sample per item and returns one
// 14-bit signed, saturated Q13.0 filter result after every fourth sample, with a
// clipped flag when saturation occurred. It accepts an item in every cycle; the
// only stall on the sample channel comes on the fourth sample of a group while the
// arithmetic pipeline is blocked by a stalled result. After that fourth sample is
// accepted, the tap pre-adds are done in the accepting cycle and registered with
// the sample; then come the registered stages of coefficient multiplies, of pair
// sums and of final sum, rounding and saturation into the output register. The
// newest group of samples sits in registers; the older samples form a window
// word in a two-entry RAM that is read, shifted by one group and written to the
// other entry each time a group completes. A forward register covers the RAM
// read latency, and a flag makes the window read as zeros until it is first
// written, so the delay line starts cleared without a clearing pass. Coefficient
// registers are written through the configuration port, which is always ready;
// indexes beyond the six coefficients are ignored. Coefficients should only be
// changed while no result is pending.

module fir_decimate_by_four_core
    import fird4_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sample_valid,
    output logic                        sample_stall,
    input  wire logic [SAMPLE_W-1:0]    adc_sample,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic signed [OUT_W-1:0]     filtered,
    output logic                        clipped,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [COEF_W-1:0]      cfg_data
);

    logic [PHASE_W-1:0] phase_reg;
    sample_t            cur_reg [DECIMATION];
    coef_t              coef_reg [NCOEF];

    logic               accept;
    logic               last_phase;
    logic               fire;
    logic               mac_busy;

    // Window memory control.
    logic [WIN_AW-1:0]  sel_reg;
    logic [WIN_AW-1:0]  sel_next;
    logic               win_valid_reg;
    logic               fwd_reg;
    logic [WIN_W-1:0]   fwd_data_reg;
    logic [WIN_W-1:0]   rd_data;
    logic [WIN_W-1:0]   win_now;
    logic [WIN_W-1:0]   win_next;

    sample_t            line [LINE_LEN];
    sym_t               sym [NCOEF];

    assign cfg_ready    = 1'b1;
    assign last_phase   = (phase_reg == PHASE_W'(DECIMATION - 1));
    assign sample_stall = last_phase && mac_busy;
    assign accept       = sample_valid && !sample_stall;
    assign fire         = accept && last_phase;

    // The window just written is not yet visible at the RAM output, so it is forwarded.
    assign win_now  = fwd_reg ? fwd_data_reg : (win_valid_reg ? rd_data : '0);
    assign sel_next = fire ? ~sel_reg : sel_reg;

    // Full delay line: index 0 is the sample arriving now, then the rest of the
    // current group newest first, then the window rows.
    always_comb
    begin
        for (int j = 0; j < DECIMATION; j++)
        begin
            if (j == 0)
            begin
                line[j] = adc_sample;
            end
            else
            begin
                line[j] = cur_reg[DECIMATION - 1 - j];
            end
        end
        for (int e = 0; e < HIST_LEN; e++)
        begin
            line[DECIMATION + e] = win_now[e * SAMPLE_W +: SAMPLE_W];
        end
    end

    // The next window is the newest part of the line, so the oldest group drops off.
    always_comb
    begin
        for (int e = 0; e < HIST_LEN; e++)
        begin
            win_next[e * SAMPLE_W +: SAMPLE_W] = line[e];
        end
    end

    // Symmetric taps share a coefficient, so their samples are added first.
    always_comb
    begin
        for (int k = 0; k < NCOEF; k++)
        begin
            if (k == TAPS - 1 - k)
            begin
                sym[k] = {1'b0, line[k]};
            end
            else
            begin
                sym[k] = {1'b0, line[k]} + {1'b0, line[TAPS - 1 - k]};
            end
        end
    end

    fird4_ram #(
        .WIDTH (WIN_W),
        .DEPTH (WIN_DEPTH)
    ) u_win_ram (
        .clk   (clk),
        .we    (fire),
        .waddr (~sel_reg),
        .wdata (win_next),
        .raddr (sel_next),
        .rdata (rd_data)
    );

    fird4_mac u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire),
        .sym          (sym),
        .coef         (coef_reg),
        .busy         (mac_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .filtered     (filtered),
        .clipped      (clipped)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            sel_reg       <= '0;
            win_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            for (int k = 0; k < NCOEF; k++)
            begin
                coef_reg[k] <= COEF_RESET[k];
            end
        end
        else
        begin
            fwd_reg <= fire;
            sel_reg <= sel_next;
            if (fire)
            begin
                win_valid_reg <= 1'b1;
            end
            if (accept)
            begin
                phase_reg <= last_phase ? '0 : phase_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_COEF_0: coef_reg[0] <= cfg_data;
                    REG_COEF_1: coef_reg[1] <= cfg_data;
                    REG_COEF_2: coef_reg[2] <= cfg_data;
                    REG_COEF_3: coef_reg[3] <= cfg_data;
                    REG_COEF_4: coef_reg[4] <= cfg_data;
                    REG_COEF_5: coef_reg[5] <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !last_phase)
        begin
            cur_reg[phase_reg] <= adc_sample;
        end
        if (fire)
        begin
            fwd_data_reg <= win_next;
        end
    end

    a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> phase_reg == '0)
        else $error("phase did not wrap after a completed group");

    a_stall_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> last_phase)
        else $error("sample channel stalled outside the last phase");

    a_fwd_window: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> fwd_reg && win_valid_reg && (sel_reg != $past(sel_reg)))
        else $error("window write not followed by forward and entry swap");

endmodule

`default_nettype wire

FILE: src/fird4_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stands alone; no package needed.
`default_nettype none

module fird4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

FILE: src/fird4_mac.sv
// Multiply-accumulate pipeline: coefficient products, pair sums, rounding and saturation.
// Depends on fird4_pkg; the last stage is the output register of the result channel.
`default_nettype none

module fird4_mac
    import fird4_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire sym_t                    sym [NCOEF],
    input  wire coef_t                   coef [NCOEF],
    output logic                         busy,
    output logic                         result_valid,
    input  wire logic                    result_stall,
    output logic signed [OUT_W-1:0]      filtered,
    output logic                         clipped
);

    logic s1_v_reg, s2_v_reg, s3_v_reg;
    logic out_hold, s3_hold, s2_hold, s1_hold;

    sym_t                     sym_reg  [NCOEF];
    logic signed [PROD_W-1:0] prod_reg [NCOEF];
    logic signed [PAIR_W-1:0] pair_reg [NPAIR];
    logic signed [PAIR_W-1:0] pair_next [NPAIR];

    logic signed [SUM_W-1:0]  total;
    logic signed [Q_W-1:0]    q;
    logic signed [OUT_W-1:0]  filtered_next;
    logic                     clipped_next;

    // A stage holds only when it is full and the stage after it holds.
    assign out_hold = result_valid && result_stall;
    assign s3_hold  = s3_v_reg && out_hold;
    assign s2_hold  = s2_v_reg && s3_hold;
    assign s1_hold  = s1_v_reg && s2_hold;
    assign busy     = s1_hold;

    always_comb
    begin
        for (int p = 0; p < NPAIR; p++)
        begin
            if (2 * p + 1 < NCOEF)
            begin
                pair_next[p] = PAIR_W'(prod_reg[2 * p]) + PAIR_W'(prod_reg[2 * p + 1]);
            end
            else
            begin
                pair_next[p] = PAIR_W'(prod_reg[2 * p]);
            end
        end
    end

    always_comb
    begin
        total = SUM_W'(signed'(1 << (SHIFT - 1)));
        for (int p = 0; p < NPAIR; p++)
        begin
            total = total + SUM_W'(pair_reg[p]);
        end
        q = total[SUM_W-1:SHIFT];
        if (q > OUT_MAX)
        begin
            filtered_next = OUT_W'(OUT_MAX);
            clipped_next  = 1'b1;
        end
        else if (q < OUT_MIN)
        begin
            filtered_next = OUT_W'(OUT_MIN);
            clipped_next  = 1'b1;
        end
        else
        begin
            filtered_next = q[OUT_W-1:0];
            clipped_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            if (!s1_hold)
            begin
                s1_v_reg <= load;
            end
            if (!s2_hold)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (!s3_hold)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (!out_hold)
            begin
                result_valid <= s3_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !s1_hold)
        begin
            sym_reg <= sym;
        end
        if (s1_v_reg && !s2_hold)
        begin
            for (int k = 0; k < NCOEF; k++)
            begin
                prod_reg[k] <= $signed({1'b0, sym_reg[k]}) * coef[k];
            end
        end
        if (s2_v_reg && !s3_hold)
        begin
            pair_reg <= pair_next;
        end
        if (s3_v_reg && !out_hold)
        begin
            filtered <= filtered_next;
            clipped  <= clipped_next;
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !s1_hold)
        else $error("item loaded into a held first stage");

    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg && !s2_hold |=> s2_v_reg)
        else $error("item lost between first and second stage");

    a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && clipped |->
            (filtered == OUT_W'(OUT_MAX)) || (filtered == OUT_W'(OUT_MIN)))
        else $error("clipped result not at a range limit");

endmodule

`default_nettype wire

FILE: dv/fir_decimate_by_four_core_tb.sv
// Self-checking testbench for fir_decimate_by_four_core: directed and random samples,
// coefficient writes and random idling on both channels, checked against a scoreboard.
// Depends on fird4_pkg and on the RTL of the filter.
`timescale 1ns / 1ps

module fir_decimate_by_four_core_tb;
    import fird4_pkg::*;

    // The run ends by force after this many cycles.
    localparam int CYCLE_LIMIT = 200000;
    // Cycles allowed after the last expected output before a coefficient write or the
    // end of the run.
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_SEGMENT_ITEMS = 150;

    // How a new set of coefficients is chosen.
    typedef enum int {
        COEFS_RESET,
        COEFS_FULL,
        COEFS_SMALL,
        COEFS_EXTREME,
        COEFS_ALL_MAX,
        COEFS_ALL_MIN
    } coef_mode_t;

    typedef struct {
        logic signed [OUT_W-1:0] filtered;
        logic                    clipped;
    } filter_output_t;

    // Bit-exact copy of the filter state: the delay line, the group phase and the
    // coefficient registers. Every accepted sample is shifted in, and each fourth one
    // queues the output the block has to produce.
    class fir_output_scoreboard;
        coef_t          coefs [NCOEF];
        sample_t        delay_line [TAPS];
        int unsigned    phase;
        int             errors;
        filter_output_t expected_outputs [$];

        function new();
            foreach (coefs[i])
                coefs[i] = COEF_RESET[i];
            foreach (delay_line[i])
                delay_line[i] = '0;
            phase = 0;
            errors = 0;
        endfunction

        function void write_coef(logic [CFG_IDX_W-1:0] index, logic [COEF_W-1:0] data);
            // Indexes past the last coefficient are ignored by the block.
            if (index < NCOEF)
                coefs[index] = coef_t'(data);
        endfunction

        function void take_sample(sample_t sample);
            longint         acc;
            longint         q;
            int             k;
            filter_output_t out;
            for (int i = TAPS - 1; i > 0; i--)
                delay_line[i] = delay_line[i - 1];
            delay_line[0] = sample;
            phase++;
            if (phase < DECIMATION)
                return;
            phase = 0;
            acc = 0;
            for (int i = 0; i < TAPS; i++)
            begin
                // Taps mirror around the center one, and each mirrored pair shares a coefficient.
                k = (i < NCOEF) ? i : TAPS - 1 - i;
                acc += longint'(delay_line[i]) * longint'(coefs[k]);
            end
            // Round half up, then the arithmetic shift floors toward minus infinity.
            q = (acc + (longint'(1) << (SHIFT - 1))) >>> SHIFT;
            out.clipped = 1'b0;
            if (q > OUT_MAX)
            begin
                q = OUT_MAX;
                out.clipped = 1'b1;
            end
            else if (q < OUT_MIN)
            begin
                q = OUT_MIN;
                out.clipped = 1'b1;
            end
            out.filtered = q[OUT_W-1:0];
            expected_outputs.push_back(out);
        endfunction

        function void check_output(logic signed [OUT_W-1:0] filtered, logic clipped);
            filter_output_t exp_out;
            if (expected_outputs.size() == 0)
            begin
                errors++;
                $display("%0t: output with none expected: filtered %0d clipped %0b",
                         $time, filtered, clipped);
                return;
            end
            exp_out = expected_outputs.pop_front();
            if (filtered !== exp_out.filtered)
            begin
                errors++;
                $display("%0t: filtered mismatch: expected %0d, actual %0d",
                         $time, exp_out.filtered, filtered);
            end
            if (clipped !== exp_out.clipped)
            begin
                errors++;
                $display("%0t: clipped mismatch: expected %0b, actual %0b",
                         $time, exp_out.clipped, clipped);
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        sample_valid = 1'b0;
    logic                        sample_stall;
    logic [SAMPLE_W-1:0]         adc_sample = '0;
    logic                        result_valid;
    logic                        result_stall = 1'b0;
    logic signed [OUT_W-1:0]     filtered;
    logic                        clipped;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [COEF_W-1:0]           cfg_data = '0;

    // Percentages of cycles in which the sample source holds back and the output
    // sink stalls. The main sequence changes them from phase to phase.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int unsigned cycles = 0;

    fir_output_scoreboard scoreboard = new();

    fir_decimate_by_four_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .adc_sample   (adc_sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .filtered     (filtered),
        .clipped      (clipped),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // The sink stalls at random. All inputs change on the falling edge, so that the
    // rising edge always sees settled values.
    always @(negedge clk)
    begin
        result_stall <= (rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct);
    end

    // An output counts as delivered at a rising edge with valid high and no stall.
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
            scoreboard.check_output(filtered, clipped);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sample values lean toward the extremes of the converter range, where the
    // products and the saturation are most likely to go wrong.
    function automatic sample_t pick_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return sample_t'($urandom_range(15));
            3:       return sample_t'($urandom_range(4095, 4032));
            default: return sample_t'($urandom_range(4095));
        endcase
    endfunction

    // Presents one item and returns on the falling edge after it was accepted. Valid
    // stays high into the next item unless the source decides to idle first.
    task automatic send_sample(input sample_t value);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        adc_sample   <= value;
        do
            @(posedge clk);
        while (sample_stall !== 1'b0);
        scoreboard.take_sample(value);
        @(negedge clk);
    endtask

    // Stops the samples and waits until every queued output has been delivered and
    // the pipeline has emptied.
    task automatic settle();
        sample_valid <= 1'b0;
        while (scoreboard.expected_outputs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes all six coefficients and then the two unused indexes with random data,
    // which the block has to ignore. Writes only happen with the block idle.
    task automatic program_coefs(input coef_mode_t mode);
        coef_t value;
        settle();
        for (int i = 0; i < (1 << CFG_IDX_W); i++)
        begin
            if (i < NCOEF)
            begin
                case (mode)
                    COEFS_RESET:   value = COEF_RESET[i];
                    COEFS_FULL:    value = coef_t'($urandom_range(65535));
                    COEFS_SMALL:   value = coef_t'(int'($urandom_range(8192)) - 4096);
                    COEFS_ALL_MAX: value = 16'sh7FFF;
                    COEFS_ALL_MIN: value = 16'sh8000;
                    default:
                    begin
                        case ($urandom_range(3))
                            0:       value = 16'sh7FFF;
                            1:       value = 16'sh8000;
                            2:       value = '0;
                            default: value = '1;
                        endcase
                    end
                endcase
            end
            else
            begin
                value = coef_t'($urandom_range(65535));
            end
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= value;
            do
                @(posedge clk);
            while (cfg_ready !== 1'b1);
            scoreboard.write_coef(CFG_IDX_W'(i), value);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, run with the first idling profile.
        tx_idle_pct = 6;
        rx_idle_pct = 48;

        // Start-up with the reset coefficients: the first outputs see a window that is
        // still partly cleared. A full-scale step, a drop to zero and a lone impulse
        // follow.
        repeat (8) send_sample('1);
        repeat (4) send_sample('0);
        send_sample('1);
        repeat (3) send_sample('0);

        // Largest coefficients with full-scale samples drive the sum far above range.
        program_coefs(COEFS_ALL_MAX);
        repeat (4) send_sample('1);

        // Most negative coefficients drive it far below range.
        program_coefs(COEFS_ALL_MIN);
        repeat (4) send_sample('1);

        // Random part: three idling profiles, each with two coefficient settings.
        // The last profile runs with no idling on either side.
        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    tx_idle_pct = 6;
                    rx_idle_pct = 48;
                end
                1:
                begin
                    tx_idle_pct = 48;
                    rx_idle_pct = 6;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int s = 0; s < 2; s++)
            begin
                program_coefs(coef_mode_t'($urandom_range(COEFS_EXTREME)));
                repeat (RANDOM_SEGMENT_ITEMS) send_sample(pick_sample());
            end
        end

        // Drain, then give any stray output time to show up before the verdict.
        settle();
        if (scoreboard.errors == 0 && scoreboard.expected_outputs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
